>>> src/gdu_pkg.sv
// ---------------------------------------------------------------------------
// gdu_pkg - shared types and constants of the Gregorian date unit
// Month tables, divider constants and the stage-to-stage structs.
// ---------------------------------------------------------------------------
package gdu_pkg;

	// last year; stepping past its end wraps to year 0
	localparam int unsigned LAST_YEAR   = 9999;
	// width of the serial day number
	localparam int unsigned SERIAL_BITS = 23;
	// year arithmetic is done at the widest supported year width
	localparam int unsigned DIV_BITS    = 16;
	// floor(p / 100) = (p * RECIP_100) >> RECIP_SHIFT, exact for p < 2^16
	localparam int unsigned RECIP_SHIFT = 23;
	localparam int unsigned RECIP_BITS  = 17;
	localparam logic [RECIP_BITS-1:0] RECIP_100 = 17'd83887;
	localparam int unsigned PROD_BITS   = DIV_BITS + RECIP_BITS;
	localparam int unsigned Q100_BITS   = PROD_BITS - RECIP_SHIFT;

	localparam logic [3:0] MONTH_JAN = 4'd1;
	localparam logic [3:0] MONTH_FEB = 4'd2;
	localparam logic [3:0] MONTH_MAR = 4'd3;
	localparam logic [3:0] MONTH_DEC = 4'd12;

	// month facts that travel from the front stage
	typedef struct packed {
		logic [3:0] month;
		logic [4:0] day;
		logic [4:0] base_len;   // month length, February as 28
		logic [8:0] days_before; // days of the months before
		logic       month_bad;
		logic       past_feb;    // month 3 or later, leap day counts
	} mon_t;

	// comparison against the other date
	typedef struct packed {
		logic is_after;
		logic is_equal;
	} cmp_t;

	// common-year month length, 0 for a bad month
	function automatic logic [4:0] month_days(input logic [3:0] m);
		logic [4:0] r;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    r = 5'd30;
			4'd2:                                       r = 5'd28;
			default:                                    r = 5'd0;
		endcase
		return r;
	endfunction

	// common-year days before the month; past December counts the whole year
	function automatic logic [8:0] days_before_month(input logic [3:0] m);
		logic [8:0] r;
		case (m)
			4'd2:    r = 9'd31;
			4'd3:    r = 9'd59;
			4'd4:    r = 9'd90;
			4'd5:    r = 9'd120;
			4'd6:    r = 9'd151;
			4'd7:    r = 9'd181;
			4'd8:    r = 9'd212;
			4'd9:    r = 9'd243;
			4'd10:   r = 9'd273;
			4'd11:   r = 9'd304;
			4'd12:   r = 9'd334;
			4'd13, 4'd14, 4'd15: r = 9'd365;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

endpackage

>>> src/gregorian_date_unit.sv
// ---------------------------------------------------------------------------
// gregorian_date_unit - Gregorian calendar date unit
// Leap flag, month length, validity, next day, serial day number and a
// compare against a second date, one result word per input word.
// ---------------------------------------------------------------------------
// Three-stage pipeline: a word taken at the input passes the stage 1 and
// stage 2 registers on its way into the output register; a new word is
// taken every cycle while the output is drained. Stage 1
// offsets the year and forms the reciprocal product for the divide by 100
// and the times-365 product; stage 2 finishes the divide, the leap flag and
// the days before the year; stage 3 settles validity, the next day and the
// serial number. Each stage holds its word while the stage after it is full
// and stalled; the output register is the last stage.
module gregorian_date_unit #(
	parameter int unsigned YEAR_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// year, month[4], day[5], other_year, other_month[4], other_day[5], zero pad
	input  logic [((2 * YEAR_BITS + 18 + 7) / 8) * 8 - 1:0] s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// date_valid, month_bad, day_bad, leap_year, month_length[5], next_year,
	// next_month[4], next_day[5], year_overflow, serial_day[23], is_after,
	// is_equal, zero pad
	output logic [((YEAR_BITS + 44 + 7) / 8) * 8 - 1:0]     m_axis_tdata
);

	localparam int unsigned OUT_USED = YEAR_BITS + 44;
	localparam int unsigned OUT_BITS = ((OUT_USED + 7) / 8) * 8;

	// input word fields
	logic [YEAR_BITS-1:0] year, other_year;
	logic [3:0]           month, other_month;
	logic [4:0]           day, other_day;

	assign year        = s_axis_tdata[YEAR_BITS-1:0];
	assign month       = s_axis_tdata[YEAR_BITS+3:YEAR_BITS];
	assign day         = s_axis_tdata[YEAR_BITS+8:YEAR_BITS+4];
	assign other_year  = s_axis_tdata[2*YEAR_BITS+8:YEAR_BITS+9];
	assign other_month = s_axis_tdata[2*YEAR_BITS+12:2*YEAR_BITS+9];
	assign other_day   = s_axis_tdata[2*YEAR_BITS+17:2*YEAR_BITS+13];

	// stage valids and ready chain
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3 = !v_s3 || m_axis_tready;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign s_axis_tready = rdy1;
	assign m_axis_tvalid = v_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= s_axis_tvalid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// stage 1
	logic [YEAR_BITS-1:0]            year_s1;
	logic                            year_zero_s1;
	logic [gdu_pkg::DIV_BITS-1:0]    prev_s1;
	logic [gdu_pkg::PROD_BITS-1:0]   prod_s1;
	logic [gdu_pkg::SERIAL_BITS-1:0] prev365_s1;
	gdu_pkg::mon_t                   mon_s1;
	gdu_pkg::cmp_t                   cmp_s1;

	gdu_front #(.YEAR_BITS(YEAR_BITS)) u_front (
		.clk          (clk),
		.en           (rdy1),
		.year         (year),
		.month        (month),
		.day          (day),
		.other_year   (other_year),
		.other_month  (other_month),
		.other_day    (other_day),
		.year_s1      (year_s1),
		.year_zero_s1 (year_zero_s1),
		.prev_s1      (prev_s1),
		.prod_s1      (prod_s1),
		.prev365_s1   (prev365_s1),
		.mon_s1       (mon_s1),
		.cmp_s1       (cmp_s1)
	);

	// stage 2
	logic [YEAR_BITS-1:0]            year_s2;
	logic                            leap_s2;
	logic [gdu_pkg::SERIAL_BITS-1:0] dby_s2;
	gdu_pkg::mon_t                   mon_s2;
	gdu_pkg::cmp_t                   cmp_s2;

	gdu_year #(.YEAR_BITS(YEAR_BITS)) u_year (
		.clk          (clk),
		.en           (rdy2),
		.year_s1      (year_s1),
		.year_zero_s1 (year_zero_s1),
		.prev_s1      (prev_s1),
		.prod_s1      (prod_s1),
		.prev365_s1   (prev365_s1),
		.mon_s1       (mon_s1),
		.cmp_s1       (cmp_s1),
		.year_s2      (year_s2),
		.leap_s2      (leap_s2),
		.dby_s2       (dby_s2),
		.mon_s2       (mon_s2),
		.cmp_s2       (cmp_s2)
	);

	// stage 3, output register
	logic                            date_valid_s3, month_bad_s3, day_bad_s3;
	logic                            leap_year_s3, year_overflow_s3;
	logic [4:0]                      month_length_s3, next_day_s3;
	logic [YEAR_BITS-1:0]            next_year_s3;
	logic [3:0]                      next_month_s3;
	logic [gdu_pkg::SERIAL_BITS-1:0] serial_day_s3;
	gdu_pkg::cmp_t                   cmp_s3;

	gdu_date #(.YEAR_BITS(YEAR_BITS)) u_date (
		.clk              (clk),
		.en               (rdy3),
		.year_s2          (year_s2),
		.leap_s2          (leap_s2),
		.dby_s2           (dby_s2),
		.mon_s2           (mon_s2),
		.cmp_s2           (cmp_s2),
		.date_valid_s3    (date_valid_s3),
		.month_bad_s3     (month_bad_s3),
		.day_bad_s3       (day_bad_s3),
		.leap_year_s3     (leap_year_s3),
		.month_length_s3  (month_length_s3),
		.next_year_s3     (next_year_s3),
		.next_month_s3    (next_month_s3),
		.next_day_s3      (next_day_s3),
		.year_overflow_s3 (year_overflow_s3),
		.serial_day_s3    (serial_day_s3),
		.cmp_s3           (cmp_s3)
	);

	// pack the result word
	assign m_axis_tdata = OUT_BITS'({
		cmp_s3.is_equal,
		cmp_s3.is_after,
		serial_day_s3,
		year_overflow_s3,
		next_day_s3,
		next_month_s3,
		next_year_s3,
		month_length_s3,
		leap_year_s3,
		day_bad_s3,
		month_bad_s3,
		date_valid_s3
	});

	// an empty output never blocks the input
	assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output stage");

	// wrap past the last year lands on January 1 of year 0
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && year_overflow_s3 |->
			date_valid_s3 && next_year_s3 == '0 &&
			next_month_s3 == gdu_pkg::MONTH_JAN && next_day_s3 == 5'd1)
		else $error("year overflow with bad next date");

	// error flags are exclusive and match validity
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> $onehot({date_valid_s3, month_bad_s3, day_bad_s3}))
		else $error("validity flags inconsistent");

	// equal and after never both set
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(cmp_s3.is_equal && cmp_s3.is_after))
		else $error("compare flags both set");

endmodule

>>> src/gdu_front.sv
// ---------------------------------------------------------------------------
// gdu_front - first pipeline stage
// Offsets the year, starts the divide by 100 and the times-365 product,
// looks up month facts and compares against the other date.
// ---------------------------------------------------------------------------
module gdu_front #(
	parameter int unsigned YEAR_BITS = 14
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [YEAR_BITS-1:0]                year,
	input  logic [3:0]                          month,
	input  logic [4:0]                          day,
	input  logic [YEAR_BITS-1:0]                other_year,
	input  logic [3:0]                          other_month,
	input  logic [4:0]                          other_day,
	output logic [YEAR_BITS-1:0]                year_s1,
	output logic                                year_zero_s1,
	output logic [gdu_pkg::DIV_BITS-1:0]        prev_s1,
	output logic [gdu_pkg::PROD_BITS-1:0]       prod_s1,
	output logic [gdu_pkg::SERIAL_BITS-1:0]     prev365_s1,
	output gdu_pkg::mon_t                       mon_s1,
	output gdu_pkg::cmp_t                       cmp_s1
);

	logic [gdu_pkg::DIV_BITS-1:0] prev;
	gdu_pkg::mon_t                mon;
	gdu_pkg::cmp_t                cmp;

	// year - 1; year 0 is handled on its own downstream
	assign prev = gdu_pkg::DIV_BITS'(year) - gdu_pkg::DIV_BITS'(1);

	// month facts
	always_comb begin
		mon.month       = month;
		mon.day         = day;
		mon.base_len    = gdu_pkg::month_days(month);
		mon.days_before = gdu_pkg::days_before_month(month);
		mon.month_bad   = (month < gdu_pkg::MONTH_JAN) || (month > gdu_pkg::MONTH_DEC);
		mon.past_feb    = (month >= gdu_pkg::MONTH_MAR);
	end

	// lexicographic compare on raw fields
	always_comb begin
		cmp.is_equal = (year == other_year) && (month == other_month) && (day == other_day);
		cmp.is_after = (year > other_year) ||
			((year == other_year) && (month > other_month)) ||
			((year == other_year) && (month == other_month) && (day > other_day));
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s1      <= year;
			year_zero_s1 <= (year == '0);
			prev_s1      <= prev;
			prod_s1      <= gdu_pkg::PROD_BITS'(prev) * gdu_pkg::PROD_BITS'(gdu_pkg::RECIP_100);
			prev365_s1   <= gdu_pkg::SERIAL_BITS'(gdu_pkg::SERIAL_BITS'(prev) *
				gdu_pkg::SERIAL_BITS'(365));
			mon_s1       <= mon;
			cmp_s1       <= cmp;
		end
	end

endmodule

>>> src/gdu_year.sv
// ---------------------------------------------------------------------------
// gdu_year - second pipeline stage
// Finishes the divide by 100, derives the leap flag and the number of
// days before the year.
// ---------------------------------------------------------------------------
module gdu_year #(
	parameter int unsigned YEAR_BITS = 14
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [YEAR_BITS-1:0]                year_s1,
	input  logic                                year_zero_s1,
	input  logic [gdu_pkg::DIV_BITS-1:0]        prev_s1,
	input  logic [gdu_pkg::PROD_BITS-1:0]       prod_s1,
	input  logic [gdu_pkg::SERIAL_BITS-1:0]     prev365_s1,
	input  gdu_pkg::mon_t                       mon_s1,
	input  gdu_pkg::cmp_t                       cmp_s1,
	output logic [YEAR_BITS-1:0]                year_s2,
	output logic                                leap_s2,
	output logic [gdu_pkg::SERIAL_BITS-1:0]     dby_s2,
	output gdu_pkg::mon_t                       mon_s2,
	output gdu_pkg::cmp_t                       cmp_s2
);

	logic [gdu_pkg::Q100_BITS-1:0]   q100;
	logic [gdu_pkg::DIV_BITS-1:0]    q100x;
	logic [6:0]                      r100;
	logic                            leap;
	logic [gdu_pkg::SERIAL_BITS-1:0] dby;

	// quotient and remainder of (year - 1) / 100
	assign q100  = prod_s1[gdu_pkg::PROD_BITS-1:gdu_pkg::RECIP_SHIFT];
	assign q100x = (gdu_pkg::DIV_BITS'(q100) << 6) + (gdu_pkg::DIV_BITS'(q100) << 5) +
		(gdu_pkg::DIV_BITS'(q100) << 2);
	assign r100  = 7'(prev_s1 - q100x);

	// year divisible by 4, 100, 400 seen as p mod 4 = 3, mod 100 = 99, mod 400 = 399
	assign leap = year_zero_s1 ||
		((prev_s1[1:0] == 2'b11) && (r100 != 7'd99)) ||
		((r100 == 7'd99) && (q100[1:0] == 2'b11));

	// days before the year, year 0 gives -366
	always_comb begin
		if (year_zero_s1) begin
			dby = -gdu_pkg::SERIAL_BITS'(366);
		end else begin
			dby = prev365_s1 + gdu_pkg::SERIAL_BITS'(prev_s1 >> 2) -
				gdu_pkg::SERIAL_BITS'(q100) + gdu_pkg::SERIAL_BITS'(q100 >> 2);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			year_s2 <= year_s1;
			leap_s2 <= leap;
			dby_s2  <= dby;
			mon_s2  <= mon_s1;
			cmp_s2  <= cmp_s1;
		end
	end

endmodule

>>> src/gdu_date.sv
// ---------------------------------------------------------------------------
// gdu_date - third pipeline stage
// Final month length, validity, next-day step and serial day number.
// ---------------------------------------------------------------------------
module gdu_date #(
	parameter int unsigned YEAR_BITS = 14
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [YEAR_BITS-1:0]                year_s2,
	input  logic                                leap_s2,
	input  logic [gdu_pkg::SERIAL_BITS-1:0]     dby_s2,
	input  gdu_pkg::mon_t                       mon_s2,
	input  gdu_pkg::cmp_t                       cmp_s2,
	output logic                                date_valid_s3,
	output logic                                month_bad_s3,
	output logic                                day_bad_s3,
	output logic                                leap_year_s3,
	output logic [4:0]                          month_length_s3,
	output logic [YEAR_BITS-1:0]                next_year_s3,
	output logic [3:0]                          next_month_s3,
	output logic [4:0]                          next_day_s3,
	output logic                                year_overflow_s3,
	output logic [gdu_pkg::SERIAL_BITS-1:0]     serial_day_s3,
	output gdu_pkg::cmp_t                       cmp_s3
);

	logic [4:0]                      len;
	logic                            day_bad;
	logic                            valid;
	logic [YEAR_BITS-1:0]            ny;
	logic [3:0]                      nm;
	logic [4:0]                      nd;
	logic                            ovf;
	logic [gdu_pkg::SERIAL_BITS-1:0] serial;

	// month length with leap February
	assign len = (mon_s2.month == gdu_pkg::MONTH_FEB && leap_s2) ? 5'd29 : mon_s2.base_len;
	assign day_bad = !mon_s2.month_bad && ((mon_s2.day == 5'd0) || (mon_s2.day > len));
	assign valid   = !mon_s2.month_bad && !day_bad;

	// next-day step; a bad date echoes itself
	always_comb begin
		ny  = year_s2;
		nm  = mon_s2.month;
		nd  = mon_s2.day;
		ovf = 1'b0;
		if (valid) begin
			if (mon_s2.day == len) begin
				nd = 5'd1;
				if (mon_s2.month == gdu_pkg::MONTH_DEC) begin
					nm = gdu_pkg::MONTH_JAN;
					if (gdu_pkg::DIV_BITS'(year_s2) >= gdu_pkg::DIV_BITS'(gdu_pkg::LAST_YEAR)) begin
						ny  = '0;
						ovf = 1'b1;
					end else begin
						ny = year_s2 + YEAR_BITS'(1);
					end
				end else begin
					nm = mon_s2.month + 4'd1;
				end
			end else begin
				nd = mon_s2.day + 5'd1;
			end
		end
	end

	// serial day: year base + month base + leap day + day
	assign serial = dby_s2 + gdu_pkg::SERIAL_BITS'(mon_s2.days_before) +
		gdu_pkg::SERIAL_BITS'(leap_s2 && mon_s2.past_feb) +
		gdu_pkg::SERIAL_BITS'(mon_s2.day);

	always_ff @(posedge clk) begin
		if (en) begin
			date_valid_s3    <= valid;
			month_bad_s3     <= mon_s2.month_bad;
			day_bad_s3       <= day_bad;
			leap_year_s3     <= leap_s2;
			month_length_s3  <= len;
			next_year_s3     <= ny;
			next_month_s3    <= nm;
			next_day_s3      <= nd;
			year_overflow_s3 <= ovf;
			serial_day_s3    <= serial;
			cmp_s3           <= cmp_s2;
		end
	end

endmodule
